// ===== rtl/core/cdq_pkg.sv =====
// shared types, operation codes and error codes for the circular deque
package cdq_pkg;

  // default storage shape
  localparam int CAPACITY_DEFAULT   = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // operation codes
  localparam logic [1:0] FUNC_PUSH_FRONT   = 2'd0;
  localparam logic [1:0] FUNC_PUSH_BACK    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE_FRONT = 2'd2;
  localparam logic [1:0] FUNC_ROTATE       = 2'd3;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // input transaction
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic signed [31:0] first_value;
    logic signed [31:0] last_value;
    logic [4:0]         count;
    logic [1:0]         error;
  } out_item_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic read;
    logic load;
  } cdq_cmd_t;

endpackage

// ===== rtl/core/cdq_ctrl.sv =====
// controller state machine: sequences update, store read and result load
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output cdq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  state_t state;

  // result register may be refilled when empty or being taken
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // commands
  assign in_stall   = (state != ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && in_valid;
  assign cmd.read   = (state == ST_READ);
  assign cmd.load   = (state == ST_LOAD) && out_free;

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // held while stalled, set by a load
      out_valid <= (out_valid && out_stall) || ((state == ST_LOAD) && out_free);
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/cdq_datapath.sv =====
// datapath: element store, front and count pointers, end values and result register
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cdq_cmd_t  cmd,
  input  in_item_t  in_item,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [IDX_W-1:0]      front;
  logic [CNT_W-1:0]      count;
  logic [DATA_WIDTH-1:0] first;
  logic [DATA_WIDTH-1:0] last;
  logic [DATA_WIDTH-1:0] rdata;
  logic [1:0]            err;
  logic                  reload;

  // decode of the incoming transaction
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] wval;
  logic [IDX_W:0]        back_sum;
  logic [IDX_W-1:0]      back_slot;
  logic [IDX_W-1:0]      next_slot;
  logic [IDX_W-1:0]      prev_slot;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign wval    = DATA_WIDTH'($unsigned(in_item.value));

  // slot arithmetic, wrapping at the capacity
  always_comb begin
    back_sum  = {1'b0, front} + (IDX_W + 1)'(count);
    if (back_sum >= (IDX_W + 1)'(CAPACITY)) begin
      back_sum = back_sum - (IDX_W + 1)'(CAPACITY);
    end
    back_slot = back_sum[IDX_W-1:0];
    next_slot = (front == LAST_SLOT) ? '0 : front + 1'b1;
    prev_slot = (front == '0) ? LAST_SLOT : front - 1'b1;
  end

  // pointer, end value and store update on an accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.accept) begin
      reload <= 1'b0;
      err    <= ERR_OK;
      case (in_item.func)
        FUNC_PUSH_FRONT: begin
          if (full) begin
            err <= ERR_FULL;
          end else begin
            front          <= prev_slot;
            mem[prev_slot] <= wval;
            count          <= count + 1'b1;
            first          <= wval;
            if (empty) begin
              last <= wval;
            end
          end
        end
        FUNC_PUSH_BACK: begin
          if (full) begin
            err <= ERR_FULL;
          end else begin
            mem[back_slot] <= wval;
            count          <= count + 1'b1;
            last           <= wval;
            if (empty) begin
              first <= wval;
            end
          end
        end
        FUNC_REMOVE_FRONT: begin
          if (empty) begin
            err <= ERR_EMPTY;
          end else begin
            front  <= next_slot;
            count  <= count - 1'b1;
            reload <= 1'b1;
          end
        end
        default: begin
          // rotate: old front moves to the back slot
          if (empty) begin
            err <= ERR_EMPTY;
          end else begin
            if (!full) begin
              mem[back_slot] <= first;
            end
            front  <= next_slot;
            last   <= first;
            reload <= 1'b1;
          end
        end
      endcase
    end else if (cmd.load && reload) begin
      first <= rdata;
    end
  end

  // registered read of the new front entry
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata <= mem[front];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (empty) begin
        out_item.first_value <= '0;
        out_item.last_value  <= '0;
      end else begin
        out_item.first_value <= reload ? 32'(rdata) : 32'(first);
        out_item.last_value  <= 32'(last);
      end
      out_item.count <= 5'(count);
      out_item.error <= err;
    end
  end

endmodule

// ===== rtl/core/circular_deque_with_rotate.sv =====
// top level of the bounded circular deque with rotate
//
// Input channel in_valid / in_stall carries one transaction: an operation
// (push front, push back, remove front, rotate front to back) and a value.
// Output channel out_valid / out_stall returns one result per transaction:
// front and back elements after the operation (zero when empty), the
// element count and an error code (empty on remove or rotate, full on push).
// A transaction passes through the update, the registered read of the new
// front entry from the single store port, and the load of the result
// register, after which its result is valid; a new transaction is taken
// only once the previous one has loaded its result.
// While the receiver stalls, the result register holds its value; the next
// transaction is still accepted and worked up to its load step, where it
// waits until the register is taken.
// Reset empties the deque at once (front and count cleared); the element
// store keeps whatever it held; an entry read before it is written never reaches a result.
module circular_deque_with_rotate
  import cdq_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  cdq_cmd_t cmd;

  // controller
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  cdq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

// ===== sim/circular_deque_with_rotate_test.sv =====
// self-checking testbench for the circular deque with rotate
module circular_deque_with_rotate_test;
  import cdq_pkg::*;

  localparam int          DEPTH        = CAPACITY_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam out_item_t   UNGIVEN      = '0;

  // which way the random operation mix leans
  typedef enum int unsigned {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

  // one row of the directed script
  typedef struct {
    logic [1:0]  func;
    logic [31:0] value;
    int unsigned reps;
    bit          given;
    out_item_t   result;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  // predicted deque contents
  logic signed [31:0] ring_slots [DEPTH];
  logic [3:0]         head_slot;
  logic [4:0]         fill_level;

  out_item_t   expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  script_row_t script [14];

  circular_deque_with_rotate dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // empty deque after reset
  function automatic void deque_clear();
    foreach (ring_slots[i]) ring_slots[i] = '0;
    head_slot  = '0;
    fill_level = '0;
  endfunction

  // apply one operation to the predicted deque and return its result
  function automatic out_item_t deque_apply(input in_item_t op);
    out_item_t  res;
    logic [3:0] back_slot;
    res = '0;
    res.error = ERR_OK;
    back_slot = head_slot + fill_level[3:0];
    case (op.func)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (fill_level == 5'(DEPTH)) begin
          res.error = ERR_FULL;
        end else if (op.func == FUNC_PUSH_FRONT) begin
          head_slot = head_slot - 4'd1;
          ring_slots[head_slot] = op.value;
          fill_level = fill_level + 5'd1;
        end else begin
          ring_slots[back_slot] = op.value;
          fill_level = fill_level + 5'd1;
        end
      end
      default: begin
        if (fill_level == 5'd0) begin
          res.error = ERR_EMPTY;
        end else if (op.func == FUNC_REMOVE_FRONT) begin
          head_slot = head_slot + 4'd1;
          fill_level = fill_level - 5'd1;
        end else begin
          // when full the front slot already is the slot past the back
          if (fill_level != 5'(DEPTH)) ring_slots[back_slot] = ring_slots[head_slot];
          head_slot = head_slot + 4'd1;
        end
      end
    endcase
    if (fill_level != 5'd0) begin
      back_slot = head_slot + fill_level[3:0] - 4'd1;
      res.first_value = ring_slots[head_slot];
      res.last_value  = ring_slots[back_slot];
    end
    res.count = fill_level;
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 9);
    else return $urandom_range(10, 40);
  endfunction

  // random operation with a leaning mix and varied values
  function automatic in_item_t random_op(input lean_t lean);
    in_item_t    op;
    int unsigned roll;
    logic [1:0]  push_func;
    push_func = $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    roll = $urandom_range(0, 99);
    case (lean)
      LEAN_FILL:
        op.func = (roll < 75) ? push_func : (roll < 85) ? FUNC_REMOVE_FRONT : FUNC_ROTATE;
      LEAN_DRAIN:
        op.func = (roll < 20) ? push_func : (roll < 85) ? FUNC_REMOVE_FRONT : FUNC_ROTATE;
      default:
        op.func = (roll < 50) ? push_func : (roll < 75) ? FUNC_REMOVE_FRONT : FUNC_ROTATE;
    endcase
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0: op.value = 32'h7fff_ffff;
        1: op.value = 32'h8000_0000;
        2: op.value = 32'h0000_0000;
        default: op.value = 32'hffff_ffff;
      endcase
    end else if (roll == 1) begin
      op.value = $urandom_range(0, 15);
    end else begin
      op.value = $urandom;
    end
    return op;
  endfunction

  // present one transaction, wait for acceptance, queue its result
  task automatic send_op(input in_item_t op, input int unsigned gap,
                         input bit given, input out_item_t given_result);
    out_item_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= op;
    do @(posedge clk); while (in_stall);
    predicted = deque_apply(op);
    expected_results.push_back(given ? given_result : predicted);
  endtask

  // receiver stalls
  initial begin : receiver_idle
    int unsigned run_len;
    int unsigned hold_len;
    out_stall <= 1'b0;
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
      hold_len = idle_gap();
      if (hold_len != 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checking
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10) $display("result with none expected: %h", out_item);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.first_value !== want.first_value ||
            out_item.last_value !== want.last_value ||
            out_item.count !== want.count ||
            out_item.error !== want.error) begin
          if (mismatch_count < 10)
            $display("mismatch: expected first %0d last %0d count %0d error %0d, got %0d %0d %0d %0d",
                     want.first_value, want.last_value, want.count, want.error,
                     out_item.first_value, out_item.last_value, out_item.count,
                     out_item.error);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    in_item_t    op;
    lean_t       lean;
    int unsigned phase_left;
    int unsigned calm_left;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    deque_clear();
    lean = LEAN_FILL;
    phase_left = 0;
    calm_left = 0;
    script = '{
      '{FUNC_REMOVE_FRONT, 32'h0,         1,  1'b1, '{32'h0, 32'h0, 5'd0, ERR_EMPTY}},
      '{FUNC_ROTATE,       32'h0,         1,  1'b1, '{32'h0, 32'h0, 5'd0, ERR_EMPTY}},
      '{FUNC_PUSH_FRONT,   32'h7fff_ffff, 1,  1'b1,
        '{32'h7fff_ffff, 32'h7fff_ffff, 5'd1, ERR_OK}},
      '{FUNC_ROTATE,       32'h0,         1,  1'b1,
        '{32'h7fff_ffff, 32'h7fff_ffff, 5'd1, ERR_OK}},
      '{FUNC_REMOVE_FRONT, 32'h0,         1,  1'b1, '{32'h0, 32'h0, 5'd0, ERR_OK}},
      '{FUNC_PUSH_BACK,    32'h8000_0000, 1,  1'b1,
        '{32'h8000_0000, 32'h8000_0000, 5'd1, ERR_OK}},
      '{FUNC_PUSH_FRONT,   32'h0,         1,  1'b1, '{32'h0, 32'h8000_0000, 5'd2, ERR_OK}},
      '{FUNC_ROTATE,       32'h0,         1,  1'b0, UNGIVEN},
      '{FUNC_PUSH_BACK,    32'hffff_ffff, 1,  1'b0, UNGIVEN},
      '{FUNC_PUSH_FRONT,   32'haaaa_aaaa, 1,  1'b0, UNGIVEN},
      '{FUNC_PUSH_BACK,    32'h5555_5555, 12, 1'b0, UNGIVEN},
      '{FUNC_PUSH_FRONT,   32'h1,         1,  1'b1,
        '{32'haaaa_aaaa, 32'h5555_5560, 5'd16, ERR_FULL}},
      '{FUNC_PUSH_BACK,    32'h2,         1,  1'b1,
        '{32'haaaa_aaaa, 32'h5555_5560, 5'd16, ERR_FULL}},
      '{FUNC_ROTATE,       32'h0,         2,  1'b0, UNGIVEN}
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed script: empty, single entry, extremes, full and rotate when full
    for (int r = 0; r < $size(script); r++) begin
      for (int unsigned k = 0; k < script[r].reps; k++) begin
        op.func  = script[r].func;
        op.value = script[r].value + k;
        send_op(op, idle_gap(), script[r].given, script[r].result);
      end
    end

    // random operations, leaning between filling and draining
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        lean = lean_t'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      if (calm_left == 0 && $urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
      // hold off until the deque has answered everything
      if (n % 500 == 250) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
      end
      if (calm_left != 0) begin
        calm_left--;
        send_op(random_op(lean), 0, 1'b0, UNGIVEN);
      end else begin
        send_op(random_op(lean), idle_gap(), 1'b0, UNGIVEN);
      end
    end

    // drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
